// ===== rtl/tlac_pkg.sv =====
// ----------------------------------------------------------------------------
// tlac_pkg
// Shared types, constants, the divide-by-255 helper and the RGB565 packer for the compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package tlac_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ProdW  = 2 * ChanW;
  localparam int unsigned PixelW = 16;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [ProdW-1:0]  prod_t;
  typedef logic [PixelW-1:0] pixel_t;

  localparam chan_t ChanMax         = 8'hFF;
  localparam chan_t AlphaFloorReset = 8'd50;

  // floor(x / 255) for x <= 255 * 255, via (x + 1 + (x >> 8)) >> 8
  function automatic chan_t div255(input prod_t x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{ProdW{1'b0}}, 1'b1} + {{(ChanW + 1){1'b0}}, x[ProdW-1:ChanW]};
    return t[ProdW-1:ChanW];
  endfunction

  function automatic pixel_t pack565(input chan_t r, input chan_t g, input chan_t b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tlac_blend.sv =====
// ----------------------------------------------------------------------------
// tlac_blend
// One channel blend, floor((a*top + (255-a)*bottom) / 255), two stages:
// products registered, then sum and divide registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tlac_blend (
  input  wire logic           clk_i,
  input  tlac_pkg::chan_t     top_i,
  input  tlac_pkg::chan_t     bottom_i,
  input  tlac_pkg::chan_t     alpha_i,
  output tlac_pkg::chan_t     result_o
);

  tlac_pkg::prod_t prod_top_d, prod_top_q;
  tlac_pkg::prod_t prod_bot_d, prod_bot_q;
  tlac_pkg::prod_t sum;
  tlac_pkg::chan_t result_d, result_q;

  // the two products sum to at most 255 * 255
  always_comb begin
    prod_top_d = tlac_pkg::ProdW'(alpha_i * top_i);
    prod_bot_d = tlac_pkg::ProdW'((tlac_pkg::ChanMax - alpha_i) * bottom_i);
    sum        = prod_top_q + prod_bot_q;
    result_d   = tlac_pkg::div255(sum);
  end

  always_ff @(posedge clk_i) begin
    prod_top_q <= prod_top_d;
    prod_bot_q <= prod_bot_d;
    result_q   <= result_d;
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== rtl/three_layer_alpha_compositor_rgb565.sv =====
// ----------------------------------------------------------------------------
// three_layer_alpha_compositor_rgb565
// Glyph over background, then half-alpha noise over that, packed to RGB565.
// ----------------------------------------------------------------------------
// Takes one pixel on every clock: busy_o stays low and start_i may be high in
// every cycle. Each pixel's result appears on pixel_rgb565_o with done_o high,
// in order, once it has passed both blend steps; the receiver cannot stall,
// so take it in that cycle. The latency comes from two blend steps in series,
// each a multiplier stage followed by an add-and-divide-by-255 stage. The
// alpha floor register may be rewritten only while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module three_layer_alpha_compositor_rgb565 (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  tlac_pkg::chan_t      cfg_wdata_i,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  tlac_pkg::chan_t      glyph_alpha_i,
  input  tlac_pkg::chan_t      glyph_red_i,
  input  tlac_pkg::chan_t      glyph_green_i,
  input  tlac_pkg::chan_t      glyph_blue_i,
  input  tlac_pkg::chan_t      back_red_i,
  input  tlac_pkg::chan_t      back_green_i,
  input  tlac_pkg::chan_t      back_blue_i,
  input  tlac_pkg::chan_t      noise_alpha_i,
  input  tlac_pkg::chan_t      noise_red_i,
  input  tlac_pkg::chan_t      noise_green_i,
  input  tlac_pkg::chan_t      noise_blue_i,
  output logic                 done_o,
  output tlac_pkg::pixel_t     pixel_rgb565_o
);

  localparam int unsigned Latency = 4;

  tlac_pkg::chan_t floor_q;
  tlac_pkg::chan_t glyph_a;
  logic [Latency-1:0] valid_d, valid_q;

  // noise layer delayed to meet the intermediate color
  tlac_pkg::chan_t na_q [2];
  tlac_pkg::chan_t nr_q [2];
  tlac_pkg::chan_t ng_q [2];
  tlac_pkg::chan_t nb_q [2];

  tlac_pkg::chan_t mid_r, mid_g, mid_b;
  tlac_pkg::chan_t out_r, out_g, out_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= tlac_pkg::AlphaFloorReset;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        floor_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
    end
  end

  always_comb begin
    glyph_a = (glyph_alpha_i < floor_q) ? floor_q : glyph_alpha_i;
    valid_d = {valid_q[Latency-2:0], start_i & ~busy_o};
  end

  always_ff @(posedge clk_i) begin
    na_q[0] <= {1'b0, noise_alpha_i[7:1]};
    nr_q[0] <= noise_red_i;
    ng_q[0] <= noise_green_i;
    nb_q[0] <= noise_blue_i;
    na_q[1] <= na_q[0];
    nr_q[1] <= nr_q[0];
    ng_q[1] <= ng_q[0];
    nb_q[1] <= nb_q[0];
  end

  tlac_blend u_glyph_r (.clk_i, .top_i(glyph_red_i),   .bottom_i(back_red_i),
                        .alpha_i(glyph_a), .result_o(mid_r));
  tlac_blend u_glyph_g (.clk_i, .top_i(glyph_green_i), .bottom_i(back_green_i),
                        .alpha_i(glyph_a), .result_o(mid_g));
  tlac_blend u_glyph_b (.clk_i, .top_i(glyph_blue_i),  .bottom_i(back_blue_i),
                        .alpha_i(glyph_a), .result_o(mid_b));

  tlac_blend u_noise_r (.clk_i, .top_i(nr_q[1]), .bottom_i(mid_r),
                        .alpha_i(na_q[1]), .result_o(out_r));
  tlac_blend u_noise_g (.clk_i, .top_i(ng_q[1]), .bottom_i(mid_g),
                        .alpha_i(na_q[1]), .result_o(out_g));
  tlac_blend u_noise_b (.clk_i, .top_i(nb_q[1]), .bottom_i(mid_b),
                        .alpha_i(na_q[1]), .result_o(out_b));

  assign busy_o         = 1'b0;
  assign done_o         = valid_q[Latency-1];
  assign pixel_rgb565_o = tlac_pkg::pack565(out_r, out_g, out_b);

endmodule

`default_nettype wire

// ===== rtl/tlac_checker.sv =====
// ----------------------------------------------------------------------------
// tlac_checker
// Port-level checks on the compositor: busy_o never raised, timing of results and an opaque case.
// ----------------------------------------------------------------------------
`default_nettype none

module tlac_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input tlac_pkg::chan_t       glyph_alpha_i,
  input tlac_pkg::chan_t       glyph_red_i,
  input tlac_pkg::chan_t       glyph_green_i,
  input tlac_pkg::chan_t       glyph_blue_i,
  input tlac_pkg::chan_t       noise_alpha_i,
  input wire logic             done_o,
  input tlac_pkg::pixel_t      pixel_rgb565_o
);

  logic             xfer;
  tlac_pkg::pixel_t glyph_only;

  assign xfer       = start_i & ~busy_o;
  assign glyph_only = tlac_pkg::pack565(glyph_red_i, glyph_green_i, glyph_blue_i);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> ##4 done_o) else $error("result missing");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(xfer, 4)) else $error("result without transfer");

  a_opaque_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && glyph_alpha_i == 8'hFF && noise_alpha_i[7:1] == 7'd0)
      |-> ##4 (pixel_rgb565_o == $past(glyph_only, 4)))
    else $error("opaque glyph not passed through");

endmodule

bind three_layer_alpha_compositor_rgb565 tlac_checker u_tlac_checker (
  .clk_i, .rst_ni, .start_i, .busy_o,
  .glyph_alpha_i, .glyph_red_i, .glyph_green_i, .glyph_blue_i,
  .noise_alpha_i, .done_o, .pixel_rgb565_o
);

`default_nettype wire
